// File: rtl/core/rld_pkg.sv
// ----------------------------------------------------------------------------
// rld_pkg
// Shared widths, fixed formats, register indexes and reset values of the
// radial lens distortion map.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

  localparam int PIX_W           = 16;
  localparam int RECIP_W         = 24;
  localparam int RECIP_FRAC_BITS = 24;
  localparam int COEF_W          = 24;
  localparam int COEF_FRAC_BITS  = 20;
  localparam int CFG_W           = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int PIX_MAX         = 65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X       = 3'd0,
    CFG_FOCAL_Y       = 3'd1,
    CFG_RECIP_FOCAL_X = 3'd2,
    CFG_RECIP_FOCAL_Y = 3'd3,
    CFG_CENTER_X      = 3'd4,
    CFG_CENTER_Y      = 3'd5,
    CFG_RADIAL_K1     = 3'd6,
    CFG_RADIAL_K2     = 3'd7
  } cfg_idx_e;

  localparam logic [PIX_W-1:0]   FOCAL_RST    = 16'd16000;
  localparam logic [RECIP_W-1:0] RECIP_RST    = 24'd16777;
  localparam logic [PIX_W-1:0]   CENTER_X_RST = 16'd10240;
  localparam logic [PIX_W-1:0]   CENTER_Y_RST = 16'd7680;
  localparam logic [COEF_W-1:0]  COEF_RST     = 24'd0;

endpackage

`default_nettype wire

// File: rtl/core/rld_in_if.sv
// ----------------------------------------------------------------------------
// rld_in_if
// Input point channel: valid/ready handshake with one pixel point.
// ----------------------------------------------------------------------------
`default_nettype none

interface rld_in_if
  import rld_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_x;
  logic [PIX_W-1:0] in_y;

  modport source (output valid, output in_x, output in_y, input ready);
  modport sink   (input valid, input in_x, input in_y, output ready);

endinterface

`default_nettype wire

// File: rtl/core/rld_out_if.sv
// ----------------------------------------------------------------------------
// rld_out_if
// Output point channel: valid/ready handshake with one mapped point and flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rld_out_if
  import rld_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_x;
  logic [PIX_W-1:0] out_y;
  logic             clipped;

  modport source (output valid, output out_x, output out_y, output clipped, input ready);
  modport sink   (input valid, input out_x, input out_y, input clipped, output ready);

endinterface

`default_nettype wire

// File: rtl/core/radial_lens_distortion_map.sv
// ----------------------------------------------------------------------------
// radial_lens_distortion_map
// Two-term radial distortion of pixel points: normalize, scale by
// 1 + k1*r^2 + k2*r^4, map back to pixels with saturation.
//
//   Channel  Dir  Handshake        Payload
//   in_i     in   valid / ready    in_x, in_y
//   out_o    out  valid / ready    out_x, out_y, clipped
//   cfg      in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// One transaction is accepted per cycle while the output is not stalled.
// After a centering subtract, the thirteen-stage datapath alternates
// multiplier stages with rounding-add stages, most of them saturating.
// Reset clears the stage valid bits and loads the register reset values.
// Each full stage holds while its successor is full and stalled, so an empty
// stage still takes data during an output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_lens_distortion_map
  import rld_pkg::*;
#(
  parameter int PIX_FRAC_BITS  = 4,
  parameter int NORM_FRAC_BITS = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  rld_in_if.sink                    in_i,
  rld_out_if.source                 out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int F          = NORM_FRAC_BITS;
  localparam int NW         = F + 4;
  localparam int DW         = PIX_W + 1;
  localparam int MW         = DW + RECIP_W + 1;
  localparam int SW         = MW + 5;
  localparam int QW         = 2 * NW;
  localparam int KW         = COEF_W + NW;
  localparam int TW         = NW + 5;
  localparam int UW         = QW + 1 - F;
  localparam int PW         = UW + DW;
  localparam int NORM_SHIFT = PIX_FRAC_BITS + RECIP_FRAC_BITS - F;
  localparam int HALF_F     = 1 << (F - 1);
  localparam int ONE_F      = 1 << F;
  localparam int HALF_C     = 1 << (COEF_FRAC_BITS - 1);
  localparam int STAGES     = 13;

  // Configuration registers.
  logic [PIX_W-1:0]   focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [RECIP_W-1:0] recip_x_q, recip_y_q;
  logic [COEF_W-1:0]  k1_q, k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_RST;
      focal_y_q  <= FOCAL_RST;
      recip_x_q  <= RECIP_RST;
      recip_y_q  <= RECIP_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      k1_q       <= COEF_RST;
      k2_q       <= COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FOCAL_X:       focal_x_q  <= cfg_data_i[PIX_W-1:0];
        CFG_FOCAL_Y:       focal_y_q  <= cfg_data_i[PIX_W-1:0];
        CFG_RECIP_FOCAL_X: recip_x_q  <= cfg_data_i[RECIP_W-1:0];
        CFG_RECIP_FOCAL_Y: recip_y_q  <= cfg_data_i[RECIP_W-1:0];
        CFG_CENTER_X:      center_x_q <= cfg_data_i[PIX_W-1:0];
        CFG_CENTER_Y:      center_y_q <= cfg_data_i[PIX_W-1:0];
        CFG_RADIAL_K1:     k1_q       <= cfg_data_i[COEF_W-1:0];
        CFG_RADIAL_K2:     k2_q       <= cfg_data_i[COEF_W-1:0];
        default:           focal_x_q  <= focal_x_q;
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or its successor loads.
  logic [STAGES:1]   vld_q;
  logic [STAGES+1:1] en;

  always_comb begin
    en[STAGES+1] = out_o.ready;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= in_i.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_i.ready = en[1];

  // Datapath registers, named by stage.
  logic signed [DW-1:0] s1_dx_q, s1_dy_q;
  logic signed [MW-1:0] s2_mx_q, s2_my_q;
  logic signed [NW-1:0] s3_nx_q, s3_ny_q;
  logic signed [QW-1:0] s4_sqx_q, s4_sqy_q;
  logic signed [NW-1:0] s4_nx_q, s4_ny_q;
  logic signed [NW-1:0] s5_r2_q, s5_nx_q, s5_ny_q;
  logic signed [QW-1:0] s6_r2sq_q;
  logic signed [KW-1:0] s6_k1r2_q;
  logic signed [NW-1:0] s6_nx_q, s6_ny_q;
  logic signed [NW-1:0] s7_r4_q, s7_nx_q, s7_ny_q;
  logic signed [TW-1:0] s7_t1_q;
  logic signed [KW-1:0] s8_k2r4_q;
  logic signed [TW-1:0] s8_t1_q;
  logic signed [NW-1:0] s8_nx_q, s8_ny_q;
  logic signed [NW-1:0] s9_s_q, s9_nx_q, s9_ny_q;
  logic signed [QW-1:0] s10_upx_q, s10_upy_q;
  logic signed [UW-1:0] s11_ux_q, s11_uy_q;
  logic signed [PW-1:0] s12_fpx_q, s12_fpy_q;
  logic [PIX_W-1:0]     s13_x_q, s13_y_q;
  logic                 s13_clip_q;

  // Stage 3 rescale of the normalization product.
  logic signed [SW-1:0] s3_wx, s3_wy;

  if (NORM_SHIFT > 0) begin : g_norm_rshift
    localparam int HALF_N = 1 << (NORM_SHIFT - 1);
    assign s3_wx = (SW'(s2_mx_q) + SW'(HALF_N)) >>> NORM_SHIFT;
    assign s3_wy = (SW'(s2_my_q) + SW'(HALF_N)) >>> NORM_SHIFT;
  end else begin : g_norm_lshift
    assign s3_wx = SW'(s2_mx_q) <<< (-NORM_SHIFT);
    assign s3_wy = SW'(s2_my_q) <<< (-NORM_SHIFT);
  end

  logic signed [NW-1:0]  s3_nx_d, s3_ny_d, s5_r2_d, s7_r4_d, s9_s_d;
  logic signed [QW:0]    s5_sum, s7_rnd, s11_rx, s11_ry;
  logic signed [KW:0]    s7_t1w, s9_t2w;
  logic signed [TW+1:0]  s9_sum;
  logic signed [PW:0]    s13_rx, s13_ry;
  logic signed [PW+1:0]  s13_px, s13_py;
  logic [PIX_W-1:0]      s13_x_d, s13_y_d;
  logic                  s13_clip_d;

  always_comb begin
    s3_nx_d = (&s3_wx[SW-1:NW-1] || !(|s3_wx[SW-1:NW-1])) ? s3_wx[NW-1:0]
            : {s3_wx[SW-1], {(NW-1){!s3_wx[SW-1]}}};
    s3_ny_d = (&s3_wy[SW-1:NW-1] || !(|s3_wy[SW-1:NW-1])) ? s3_wy[NW-1:0]
            : {s3_wy[SW-1], {(NW-1){!s3_wy[SW-1]}}};

    s5_sum  = ((QW+1)'(s4_sqx_q) + (QW+1)'(s4_sqy_q) + (QW+1)'(HALF_F)) >>> F;
    s5_r2_d = (&s5_sum[QW:NW-1] || !(|s5_sum[QW:NW-1])) ? s5_sum[NW-1:0]
            : {s5_sum[QW], {(NW-1){!s5_sum[QW]}}};

    s7_rnd  = ((QW+1)'(s6_r2sq_q) + (QW+1)'(HALF_F)) >>> F;
    s7_r4_d = (&s7_rnd[QW:NW-1] || !(|s7_rnd[QW:NW-1])) ? s7_rnd[NW-1:0]
            : {s7_rnd[QW], {(NW-1){!s7_rnd[QW]}}};
    s7_t1w  = ((KW+1)'(s6_k1r2_q) + (KW+1)'(HALF_C)) >>> COEF_FRAC_BITS;

    s9_t2w  = ((KW+1)'(s8_k2r4_q) + (KW+1)'(HALF_C)) >>> COEF_FRAC_BITS;
    s9_sum  = (TW+2)'(ONE_F) + (TW+2)'(s8_t1_q) + (TW+2)'($signed(s9_t2w[TW-1:0]));
    s9_s_d  = (&s9_sum[TW+1:NW-1] || !(|s9_sum[TW+1:NW-1])) ? s9_sum[NW-1:0]
            : {s9_sum[TW+1], {(NW-1){!s9_sum[TW+1]}}};

    s11_rx  = ((QW+1)'(s10_upx_q) + (QW+1)'(HALF_F)) >>> F;
    s11_ry  = ((QW+1)'(s10_upy_q) + (QW+1)'(HALF_F)) >>> F;

    s13_rx  = ((PW+1)'(s12_fpx_q) + (PW+1)'(HALF_F)) >>> F;
    s13_ry  = ((PW+1)'(s12_fpy_q) + (PW+1)'(HALF_F)) >>> F;
    s13_px  = (PW+2)'(s13_rx) + (PW+2)'($signed({1'b0, center_x_q}));
    s13_py  = (PW+2)'(s13_ry) + (PW+2)'($signed({1'b0, center_y_q}));

    s13_clip_d = 1'b0;
    if (s13_px[PW+1]) begin
      s13_x_d    = '0;
      s13_clip_d = 1'b1;
    end else if (|s13_px[PW+1:PIX_W]) begin
      s13_x_d    = PIX_W'(PIX_MAX);
      s13_clip_d = 1'b1;
    end else begin
      s13_x_d = s13_px[PIX_W-1:0];
    end
    if (s13_py[PW+1]) begin
      s13_y_d    = '0;
      s13_clip_d = 1'b1;
    end else if (|s13_py[PW+1:PIX_W]) begin
      s13_y_d    = PIX_W'(PIX_MAX);
      s13_clip_d = 1'b1;
    end else begin
      s13_y_d = s13_py[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_dx_q <= $signed({1'b0, in_i.in_x}) - $signed({1'b0, center_x_q});
      s1_dy_q <= $signed({1'b0, in_i.in_y}) - $signed({1'b0, center_y_q});
    end
    if (en[2]) begin
      s2_mx_q <= MW'(s1_dx_q) * MW'($signed({1'b0, recip_x_q}));
      s2_my_q <= MW'(s1_dy_q) * MW'($signed({1'b0, recip_y_q}));
    end
    if (en[3]) begin
      s3_nx_q <= s3_nx_d;
      s3_ny_q <= s3_ny_d;
    end
    if (en[4]) begin
      s4_sqx_q <= QW'(s3_nx_q) * QW'(s3_nx_q);
      s4_sqy_q <= QW'(s3_ny_q) * QW'(s3_ny_q);
      s4_nx_q  <= s3_nx_q;
      s4_ny_q  <= s3_ny_q;
    end
    if (en[5]) begin
      s5_r2_q <= s5_r2_d;
      s5_nx_q <= s4_nx_q;
      s5_ny_q <= s4_ny_q;
    end
    if (en[6]) begin
      s6_r2sq_q <= QW'(s5_r2_q) * QW'(s5_r2_q);
      s6_k1r2_q <= KW'($signed(k1_q)) * KW'(s5_r2_q);
      s6_nx_q   <= s5_nx_q;
      s6_ny_q   <= s5_ny_q;
    end
    if (en[7]) begin
      s7_r4_q <= s7_r4_d;
      s7_t1_q <= s7_t1w[TW-1:0];
      s7_nx_q <= s6_nx_q;
      s7_ny_q <= s6_ny_q;
    end
    if (en[8]) begin
      s8_k2r4_q <= KW'($signed(k2_q)) * KW'(s7_r4_q);
      s8_t1_q   <= s7_t1_q;
      s8_nx_q   <= s7_nx_q;
      s8_ny_q   <= s7_ny_q;
    end
    if (en[9]) begin
      s9_s_q  <= s9_s_d;
      s9_nx_q <= s8_nx_q;
      s9_ny_q <= s8_ny_q;
    end
    if (en[10]) begin
      s10_upx_q <= QW'(s9_nx_q) * QW'(s9_s_q);
      s10_upy_q <= QW'(s9_ny_q) * QW'(s9_s_q);
    end
    if (en[11]) begin
      s11_ux_q <= s11_rx[UW-1:0];
      s11_uy_q <= s11_ry[UW-1:0];
    end
    if (en[12]) begin
      s12_fpx_q <= PW'(s11_ux_q) * PW'($signed({1'b0, focal_x_q}));
      s12_fpy_q <= PW'(s11_uy_q) * PW'($signed({1'b0, focal_y_q}));
    end
    if (en[13]) begin
      s13_x_q    <= s13_x_d;
      s13_y_q    <= s13_y_d;
      s13_clip_q <= s13_clip_d;
    end
  end

  assign out_o.valid   = vld_q[STAGES];
  assign out_o.out_x   = s13_x_q;
  assign out_o.out_y   = s13_y_q;
  assign out_o.clipped = s13_clip_q;

endmodule

`default_nettype wire
